[rtl/core/itr_pkg.sv]
// itr_pkg: shared types and constants for the interval timer with reload
// no dependencies; imported by the interfaces and all timer modules
package itr_pkg;

    localparam int unsigned TimeW = 32;

    localparam logic [TimeW-1:0] DefaultPeriod = TimeW'(30000);
    localparam logic [TimeW-1:0] AllOnes       = '1;

    // command codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_CHECK      = 3'd1,
        KIND_START      = 3'd2,
        KIND_SET_PERIOD = 3'd3,
        KIND_SET_RELOAD = 3'd4,
        KIND_TRIGGER    = 3'd5,
        KIND_DISABLE    = 3'd6,
        KIND_ENABLE     = 3'd7
    } itr_kind_t;

    typedef logic [TimeW-1:0] itr_time_t;

    // status computed from the timer state before an update
    typedef struct packed {
        logic      expired;
        itr_time_t elapsed;
        itr_time_t remaining;
    } itr_status_t;

endpackage

[rtl/core/itr_if.sv]
// itr_if: valid/ready channel interfaces for timer commands and results
// depends on itr_pkg
interface itr_cmd_if
    import itr_pkg::*;
;
    logic      valid;
    logic      ready;
    itr_kind_t kind;
    itr_time_t value;
    logic      flag;

    modport source (output valid, kind, value, flag, input ready);
    modport sink   (input valid, kind, value, flag, output ready);
endinterface

interface itr_res_if
    import itr_pkg::*;
;
    logic      valid;
    logic      ready;
    logic      expired;
    itr_time_t elapsed;
    itr_time_t remaining;

    modport source (output valid, expired, elapsed, remaining, input ready);
    modport sink   (input valid, expired, elapsed, remaining, output ready);
endinterface

[rtl/core/itr_status.sv]
// itr_status: expiry flag, elapsed and remaining time from the timer state
// depends on itr_pkg
module itr_status
    import itr_pkg::*;
(
    input  itr_time_t   clock_now,
    input  itr_time_t   start_stamp,
    input  itr_time_t   period_now,
    input  logic        running,
    output itr_status_t status
);

    itr_time_t since;
    logic      over;

    // elapsed time wraps mod 2^32
    assign since = clock_now - start_stamp;
    assign over  = running && (since > period_now);

    always_comb
    begin
        status.expired = over;
        if (!running)
        begin
            status.elapsed   = AllOnes;
            status.remaining = AllOnes;
        end
        else
        begin
            status.elapsed   = since;
            status.remaining = over ? '0 : (period_now - since);
        end
    end

endmodule

[rtl/core/interval_timer_with_reload.sv]
// interval timer with reload: one command beat in, one result beat out
// the result of a command beat is registered and valid in the cycle after it is accepted
// throughput: one command per cycle while the result side takes every beat
// a held result stalls the command side through the output register
// reset (rst_n low, async): clock 0, start stamp 0, period and reload 30000,
// timer disabled, exact_restart 0, no result pending
module interval_timer_with_reload
    import itr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    itr_cmd_if.sink       cmd,
    itr_res_if.source     res,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    logic        exact_restart_reg;
    itr_time_t   clock_now_reg,   clock_now_next;
    itr_time_t   start_stamp_reg, start_stamp_next;
    itr_time_t   period_reg,      period_next;
    itr_time_t   reload_reg,      reload_next;
    logic        running_reg,     running_next;

    logic        res_valid_reg;
    logic        res_expired_reg;
    itr_time_t   res_elapsed_reg;
    itr_time_t   res_remaining_reg;

    itr_status_t status;
    logic        cmd_fire;
    logic        value_nz;

    // status from the state before this beat's update
    itr_status u_status (
        .clock_now   (clock_now_reg),
        .start_stamp (start_stamp_reg),
        .period_now  (period_reg),
        .running     (running_reg),
        .status      (status)
    );

    // accept while the output register is empty or draining
    assign cmd.ready = !res_valid_reg || res.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign value_nz  = (cmd.value != '0);

    // next timer state per command
    always_comb
    begin
        clock_now_next   = clock_now_reg;
        start_stamp_next = start_stamp_reg;
        period_next      = period_reg;
        reload_next      = reload_reg;
        running_next     = running_reg;
        unique case (cmd.kind)
            KIND_TICK:
            begin
                clock_now_next = clock_now_reg + cmd.value;
            end
            KIND_CHECK:
            begin
                if (status.expired && cmd.flag)
                begin
                    start_stamp_next = exact_restart_reg ? (start_stamp_reg + period_reg)
                                                         : clock_now_reg;
                    period_next      = reload_reg;
                end
            end
            KIND_START:
            begin
                start_stamp_next = clock_now_reg;
                running_next     = 1'b1;
                if (value_nz)
                begin
                    period_next = cmd.value;
                    if (cmd.flag)
                    begin
                        reload_next = cmd.value;
                    end
                end
            end
            KIND_SET_PERIOD:
            begin
                if (!running_reg)
                begin
                    start_stamp_next = clock_now_reg;
                    running_next     = 1'b1;
                end
                if (value_nz)
                begin
                    period_next = cmd.value;
                    reload_next = cmd.value;
                end
            end
            KIND_SET_RELOAD:
            begin
                reload_next = cmd.value;
                if (cmd.flag)
                begin
                    running_next = 1'b1;
                end
            end
            KIND_TRIGGER:
            begin
                running_next     = 1'b1;
                period_next      = reload_reg;
                start_stamp_next = clock_now_reg - reload_reg - TimeW'(1);
            end
            KIND_DISABLE:
            begin
                running_next = 1'b0;
            end
            KIND_ENABLE:
            begin
                running_next = 1'b1;
            end
        endcase
    end

    // timer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_restart_reg <= 1'b0;
            clock_now_reg     <= '0;
            start_stamp_reg   <= '0;
            period_reg        <= DefaultPeriod;
            reload_reg        <= DefaultPeriod;
            running_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                exact_restart_reg <= cfg_wr_data;
            end
            if (cmd_fire)
            begin
                clock_now_reg   <= clock_now_next;
                start_stamp_reg <= start_stamp_next;
                period_reg      <= period_next;
                reload_reg      <= reload_next;
                running_reg     <= running_next;
            end
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_expired_reg   <= status.expired;
            res_elapsed_reg   <= status.elapsed;
            res_remaining_reg <= status.remaining;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.expired   = res_expired_reg;
    assign res.elapsed   = res_elapsed_reg;
    assign res.remaining = res_remaining_reg;

endmodule

[rtl/core/itr_checker.sv]
// itr_checker: port-level assertions for the interval timer with reload
// depends on itr_pkg; bound to interval_timer_with_reload below
module itr_checker
    import itr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      res_valid,
    input logic      res_ready,
    input logic      res_expired,
    input itr_time_t res_elapsed,
    input itr_time_t res_remaining
);

    // a stalled result beat keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(res_expired) && $stable(res_elapsed) && $stable(res_remaining))
        else $error("result beat changed while stalled");

    // every accepted command beat shows a result the next cycle
    a_cmd_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("no result after accepted command");

    // no command taken while a result is held
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("command accepted over a held result");

    // expired results report no remaining time
    a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_expired |-> (res_remaining == '0))
        else $error("expired result with nonzero remaining time");

    // a disabled reading shows all ones in both times; a running one with all-ones remaining has zero elapsed
    a_disabled_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_remaining == AllOnes) && !res_expired |->
            (res_elapsed == AllOnes) || (res_elapsed == '0))
        else $error("all-ones remaining time with inconsistent elapsed time");

endmodule

bind interval_timer_with_reload itr_checker u_itr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_expired   (res.expired),
    .res_elapsed   (res.elapsed),
    .res_remaining (res.remaining)
);
